>>> hdl/wcre_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and controller/datapath interface types.
package wcre_pkg;

   localparam int ALT_W      = 18;     // altitude sample, signed feet
   localparam int MS_W       = 10;     // millisecond field
   localparam int RATE_W     = 18;     // climb rate result, signed ft/min
   localparam int MS_MOD     = 1000;   // timestamp wraps at one second
   localparam int RATE_SCALE = 60000;  // ms per minute
   localparam int CHG_W      = ALT_W + 1;
   localparam int PROD_W     = CHG_W + 16;    // change * 60000, signed
   localparam int MAG_W      = PROD_W - 1;    // magnitude of the product
   localparam int HI_W       = MAG_W - RATE_W;
   localparam int STEP_W     = $clog2(RATE_W);

   localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

   typedef struct packed {
      logic load_in;      // capture the input transfer
      logic store;        // write sample, update running sum, read oldest
      logic take_change;  // altitude change, read next-oldest
      logic mul_drop;     // scale the change, retire the oldest sample
      logic prep;         // zero / saturation checks, divider set-up
      logic div_step;     // one quotient bit
      logic finish;       // apply sign and clamp
      logic out_load;     // move result into the output register
   } ctl_cmd_type;

   typedef struct packed {
      logic window_full;   // window already holds WINDOW-1 samples
      logic elapsed_zero;
      logic too_big;       // quotient would not fit in RATE_W bits
      logic out_free;      // output register can take a new result
   } dp_status_type;

endpackage

>>> hdl/wcre_ctl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the climb-rate estimator.
module wcre_ctl import wcre_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_STORE, ST_RD_OLD, ST_MUL, ST_PREP, ST_DIV, ST_FIN, ST_OUT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_STORE;
            end
            ST_STORE: begin
               state_ff <= status.window_full ? ST_RD_OLD : ST_OUT;
            end
            ST_RD_OLD: state_ff <= ST_MUL;
            ST_MUL:    state_ff <= ST_PREP;
            ST_PREP: begin
               step_ff <= STEP_W'(RATE_W - 1);
               if (status.elapsed_zero || status.too_big) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) state_ff <= ST_FIN;
            end
            ST_FIN: state_ff <= ST_OUT;
            ST_OUT: begin
               if (status.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.load_in     = (state_ff == ST_IDLE) && req_valid;
      cmd.store       = (state_ff == ST_STORE);
      cmd.take_change = (state_ff == ST_RD_OLD);
      cmd.mul_drop    = (state_ff == ST_MUL);
      cmd.prep        = (state_ff == ST_PREP);
      cmd.div_step    = (state_ff == ST_DIV);
      cmd.finish      = (state_ff == ST_FIN);
      cmd.out_load    = (state_ff == ST_OUT) && status.out_free;
   end

endmodule

>>> hdl/wcre_dp.sv
`timescale 1ns / 1ps
// Datapath: sample ring, running elapsed sum, scaling multiplier, serial divider.
module wcre_dp import wcre_pkg::*; #(
   parameter int WINDOW = 50
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [ALT_W-1:0]  req_altitude_ft,
   input  logic        [MS_W-1:0]   req_millis,
   input  logic                     rsp_stall,
   input  ctl_cmd_type              cmd,
   output dp_status_type            status,
   output logic                     rsp_valid,
   output logic signed [RATE_W-1:0] rsp_climb_rate_fpm,
   output logic                     rsp_window_full
);

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int ELAP_W = $clog2((WINDOW - 1) * (MS_MOD - 1) + 1);
   localparam int REM_W  = ((ELAP_W > HI_W) ? ELAP_W : HI_W) + 1;
   localparam int WORD_W = ALT_W + MS_W;
   localparam logic [IDX_W-1:0]         LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic signed [MS_W+1:0]   MOD_S    = (MS_W + 2)'(MS_MOD);
   localparam logic signed [PROD_W-1:0] SCALE_S  = PROD_W'(RATE_SCALE);

   // ring word: altitude, then time step from the previous sample
   logic [WORD_W-1:0] mem [WINDOW];

   logic signed [ALT_W-1:0]  alt_in_ff;
   logic [MS_W-1:0]          ms_in_ff;
   logic [MS_W-1:0]          last_ms_ff;
   logic [IDX_W-1:0]         wr_ptr_ff;
   logic [IDX_W-1:0]         oldest_ff;
   logic [IDX_W-1:0]         fill_ff;
   logic [ELAP_W-1:0]        sum_ff;
   logic [ELAP_W-1:0]        elapsed_ff;
   logic [WORD_W-1:0]        rd_data_ff;
   logic signed [CHG_W-1:0]  change_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [RATE_W-1:0]        quot_ff;
   logic [RATE_W-1:0]        lo_ff;
   logic                     neg_ff;
   logic signed [RATE_W-1:0] res_rate_ff;
   logic                     res_full_ff;
   logic                     rsp_valid_ff;
   logic signed [RATE_W-1:0] rsp_rate_ff;
   logic                     rsp_full_ff;

   logic signed [MS_W+1:0]   diff_raw;
   logic signed [MS_W+1:0]   diff_mod;
   logic [MS_W-1:0]          diff;
   logic [ELAP_W-1:0]        sum_add;
   logic                     is_full;
   logic [IDX_W-1:0]         wr_next;
   logic [IDX_W-1:0]         oldest_next;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [ALT_W-1:0]  rd_alt;
   logic [MS_W-1:0]          rd_diff;
   logic [MAG_W-1:0]         mag;
   logic [REM_W-1:0]         elapsed_ext;
   logic [REM_W-1:0]         trial;
   logic                     fits;
   logic signed [RATE_W-1:0] sat_rate;
   logic signed [RATE_W-1:0] fin_rate;

   // time step modulo one second, kept non-negative
   always_comb begin
      diff_raw = $signed({2'b00, ms_in_ff}) - $signed({2'b00, last_ms_ff});
      diff_mod = diff_raw;
      if (diff_raw < 0) begin
         diff_mod = diff_raw + MOD_S;
         if (diff_mod < 0) diff_mod = diff_mod + MOD_S;
      end else if (diff_raw >= MOD_S) begin
         diff_mod = diff_raw - MOD_S;
      end
      diff = diff_mod[MS_W-1:0];
   end

   assign sum_add     = sum_ff + ELAP_W'(diff);
   assign is_full     = (fill_ff == LAST_IDX);
   assign wr_next     = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
   assign oldest_next = (oldest_ff == LAST_IDX) ? '0 : oldest_ff + 1'b1;
   assign rd_addr     = cmd.store ? oldest_ff : oldest_next;
   assign rd_alt      = $signed(rd_data_ff[WORD_W-1:MS_W]);
   assign rd_diff     = rd_data_ff[MS_W-1:0];

   assign mag         = prod_ff[PROD_W-1] ? MAG_W'(-prod_ff) : MAG_W'(prod_ff);
   assign elapsed_ext = REM_W'(elapsed_ff);
   assign trial       = {rem_ff[REM_W-2:0], lo_ff[RATE_W-1]};
   assign fits        = (trial >= elapsed_ext);
   assign sat_rate    = prod_ff[PROD_W-1] ? RATE_MIN : RATE_MAX;

   always_comb begin
      if (quot_ff[RATE_W-1]) begin
         fin_rate = neg_ff ? RATE_MIN : RATE_MAX;
      end else if (neg_ff) begin
         fin_rate = -$signed(quot_ff);
      end else begin
         fin_rate = $signed(quot_ff);
      end
   end

   always_comb begin
      status              = '0;
      status.window_full  = is_full;
      status.elapsed_zero = (elapsed_ff == '0);
      status.too_big      = (REM_W'(mag[MAG_W-1:RATE_W]) >= elapsed_ext);
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.store) mem[wr_ptr_ff] <= {alt_in_ff, diff};
      rd_data_ff <= mem[rd_addr];
   end

   // ring control and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         oldest_ff    <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.store) begin
            wr_ptr_ff <= wr_next;
            if (fill_ff != '0) sum_ff <= sum_add;
            if (!is_full) fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.mul_drop) begin
            sum_ff    <= sum_ff - ELAP_W'(rd_diff);
            oldest_ff <= oldest_next;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         alt_in_ff <= req_altitude_ft;
         ms_in_ff  <= req_millis;
      end
      if (cmd.store) begin
         last_ms_ff <= ms_in_ff;
         elapsed_ff <= sum_add;
         if (!is_full) begin
            res_rate_ff <= '0;
            res_full_ff <= 1'b0;
         end
      end
      if (cmd.take_change) change_ff <= CHG_W'(alt_in_ff) - CHG_W'(rd_alt);
      if (cmd.mul_drop) prod_ff <= change_ff * SCALE_S;
      if (cmd.prep) begin
         neg_ff  <= prod_ff[PROD_W-1];
         rem_ff  <= REM_W'(mag[MAG_W-1:RATE_W]);
         lo_ff   <= mag[RATE_W-1:0];
         quot_ff <= '0;
         res_full_ff <= 1'b1;
         if (status.elapsed_zero) begin
            res_rate_ff <= '0;
         end else if (status.too_big) begin
            res_rate_ff <= sat_rate;
         end
      end
      if (cmd.div_step) begin
         rem_ff  <= fits ? trial - elapsed_ext : trial;
         quot_ff <= {quot_ff[RATE_W-2:0], fits};
         lo_ff   <= {lo_ff[RATE_W-2:0], 1'b0};
      end
      if (cmd.finish) res_rate_ff <= fin_rate;
      if (cmd.out_load) begin
         rsp_rate_ff <= res_rate_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_climb_rate_fpm = rsp_rate_ff;
   assign rsp_window_full    = rsp_full_ff;

endmodule

>>> hdl/windowed_climb_rate_estimator.sv
`timescale 1ns / 1ps
// Top level of the windowed climb-rate estimator.
//
// Takes altitude samples (whole feet) with their millisecond-of-second stamp
// and keeps the last WINDOW of them in a ring memory. Until the window is full
// every result is zero with window_full low; after that each sample gives the
// climb rate in ft/min over the window, 60000 * (newest - oldest) / elapsed ms,
// truncated toward zero and clamped to 18 bits signed (zero if no time has
// passed). Elapsed time is a running sum of per-sample steps (each taken modulo
// 1000), so nothing is rescanned per sample. One sample is in flight at a time.
// While the window fills, the result goes through the store and output states
// to the output register. Once full it also passes the read, scale and check
// states, then the one-bit-per-cycle restoring divider and the sign step;
// with no elapsed time or a quotient out of range the divider is skipped.
// The next request transfer can be taken in the cycle after the output load.
// Results sit in an output register, so the next request transfer
// is taken while an earlier result still waits on rsp_stall; a result that
// finds the register still occupied waits there and holds off the input.
// The sample ring needs no clearing after reset: slots are only read once
// written.
module windowed_climb_rate_estimator import wcre_pkg::*; #(
   parameter int WINDOW = 50
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ALT_W-1:0]  req_altitude_ft,
   input  logic        [MS_W-1:0]   req_millis,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [RATE_W-1:0] rsp_climb_rate_fpm,
   output logic                     rsp_window_full
);

   ctl_cmd_type   cmd;     // controller -> datapath
   dp_status_type status;  // datapath -> controller

   // sequencing: store, read oldest, scale, checks, divide, sign, output
   wcre_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // ring, elapsed sum, multiplier, divider and output register
   wcre_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_altitude_ft    (req_altitude_ft),
      .req_millis         (req_millis),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_climb_rate_fpm (rsp_climb_rate_fpm),
      .rsp_window_full    (rsp_window_full)
   );

endmodule

>>> hdl/wcre_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the climb-rate estimator, bound to the top level.
module wcre_checker import wcre_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [RATE_W-1:0] rsp_climb_rate_fpm,
   input logic                     rsp_window_full
);

   // one sample in flight: a request transfer closes the input for a while
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous sample still in work");

   // a window that is not yet full reports a zero rate
   a_zero_until_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_full |-> rsp_climb_rate_fpm == '0)
      else $error("non-zero rate before window full");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_climb_rate_fpm) && $stable(rsp_window_full))
      else $error("response changed while stalled");

endmodule

bind windowed_climb_rate_estimator wcre_checker u_wcre_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_climb_rate_fpm (rsp_climb_rate_fpm),
   .rsp_window_full    (rsp_window_full)
);
